// File: src/dbdnr_pkg.sv
// Shared types and constants for the digit-by-digit n-th root block.
`default_nettype none
package dbdnr_pkg;

  localparam int unsigned IN_W   = 32;
  localparam int unsigned POW_W  = 4;
  localparam int unsigned LIMB_W = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIAL,
    S_MUL,
    S_CMP,
    S_DONE
  } dbdnr_state_e;

  typedef struct packed {
    logic ready;
    logic done;
  } dbdnr_status_t;

endpackage
`default_nettype wire

// File: src/dbdnr_limb_mac.sv
// Limb multiply-accumulate unit shared by every trial power multiplication.
`default_nettype none
module dbdnr_limb_mac #(
  parameter int unsigned LIMB_BITS = 32,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic [LIMB_BITS-1:0] a_i,
  input  wire logic [WORD_BITS-1:0] b_i,
  input  wire logic [WORD_BITS-1:0] c_i,
  output logic      [LIMB_BITS-1:0] lo_o,
  output logic      [WORD_BITS-1:0] hi_o
);

  localparam int unsigned SUM_W = LIMB_BITS + WORD_BITS;

  logic [SUM_W-1:0] sum;

  assign sum  = SUM_W'(a_i) * SUM_W'(b_i) + SUM_W'(c_i);
  assign lo_o = sum[LIMB_BITS-1:0];
  assign hi_o = sum[SUM_W-1:LIMB_BITS];

endmodule
`default_nettype wire

// File: src/dbdnr_core.sv
// Sequencer and datapath that decide the root one bit at a time.
`default_nettype none
module dbdnr_core #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned MAX_POWER = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [WORD_BITS-1:0]         radicand_i,
  input  wire logic [dbdnr_pkg::POW_W-1:0]  root_power_i,
  input  wire logic                         ack_i,
  output dbdnr_pkg::dbdnr_status_t          status_o,
  output logic      [WORD_BITS-1:0]         root_o
);

  import dbdnr_pkg::*;

  localparam int unsigned LW    = LIMB_W;
  localparam int unsigned ACC_W = WORD_BITS + FRAC_BITS * (MAX_POWER - 1);
  localparam int unsigned NL    = (ACC_W + LW - 1) / LW;
  localparam int unsigned VW    = NL * LW;
  localparam int unsigned LCW   = (NL > 1) ? $clog2(NL) : 1;
  localparam int unsigned BW    = $clog2(WORD_BITS);
  localparam int unsigned MCW   = $clog2(MAX_POWER);
  localparam int unsigned SHW   = $clog2(VW + 1);

  dbdnr_state_e state_q, state_d;

  logic [BW-1:0]        bit_q, bit_d;
  logic [LCW-1:0]       limb_q, limb_d;
  logic [MCW-1:0]       mcnt_q, mcnt_d;
  logic [MCW-1:0]       nm1_q, nm1_d;
  logic                 ovf_q, ovf_d;
  logic [WORD_BITS-1:0] root_q, root_d;
  logic [WORD_BITS-1:0] carry_q, carry_d;
  logic [VW-1:0]        bound_q, bound_d;
  logic [LW-1:0]        acc_q [NL];
  logic [LW-1:0]        acc_d [NL];

  logic [WORD_BITS-1:0] trial;
  logic [VW-1:0]        trial_vec;
  logic [VW-1:0]        acc_vec;
  logic [LW-1:0]        mac_lo;
  logic [WORD_BITS-1:0] mac_hi;
  logic                 last_limb;
  logic                 keep;
  logic [POW_W:0]       pow_ext;
  logic [POW_W:0]       pow_m1;
  logic [MCW-1:0]       nm1_in;
  logic [SHW-1:0]       shamt;

  assign trial     = root_q | (WORD_BITS'(1) << bit_q);
  assign trial_vec = VW'(trial);
  assign last_limb = (limb_q == LCW'(NL - 1));
  assign keep      = !ovf_q && (acc_vec <= bound_q);

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      acc_vec[i*LW +: LW] = acc_q[i];
    end
  end

  assign pow_ext = {1'b0, root_power_i};
  assign pow_m1  = pow_ext - (POW_W + 1)'(1);

  always_comb begin
    if (root_power_i == '0) begin
      nm1_in = '0;
    end else if (pow_ext > (POW_W + 1)'(MAX_POWER)) begin
      nm1_in = MCW'(MAX_POWER - 1);
    end else begin
      nm1_in = pow_m1[MCW-1:0];
    end
  end

  assign shamt = SHW'(nm1_in) * SHW'(FRAC_BITS);

  dbdnr_limb_mac #(
    .LIMB_BITS (LW),
    .WORD_BITS (WORD_BITS)
  ) u_mac (
    .a_i  (acc_q[limb_q]),
    .b_i  (trial),
    .c_i  (carry_q),
    .lo_o (mac_lo),
    .hi_o (mac_hi)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_TRIAL;
      end
      S_TRIAL: begin
        state_d = (nm1_q == '0) ? S_CMP : S_MUL;
      end
      S_MUL: begin
        if (last_limb && ((mac_hi != '0) || (mcnt_q == MCW'(1)))) state_d = S_CMP;
      end
      S_CMP: begin
        state_d = (bit_q == '0) ? S_DONE : S_TRIAL;
      end
      S_DONE: begin
        if (ack_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    bit_d   = bit_q;
    limb_d  = limb_q;
    mcnt_d  = mcnt_q;
    nm1_d   = nm1_q;
    ovf_d   = ovf_q;
    root_d  = root_q;
    carry_d = carry_q;
    bound_d = bound_q;
    acc_d   = acc_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          nm1_d   = nm1_in;
          bound_d = VW'(radicand_i) << shamt;
          root_d  = '0;
          bit_d   = BW'(WORD_BITS - 1);
        end
      end
      S_TRIAL: begin
        for (int i = 0; i < NL; i++) begin
          acc_d[i] = trial_vec[i*LW +: LW];
        end
        mcnt_d  = nm1_q;
        ovf_d   = 1'b0;
        limb_d  = '0;
        carry_d = '0;
      end
      S_MUL: begin
        acc_d[limb_q] = mac_lo;
        carry_d       = mac_hi;
        if (last_limb) begin
          limb_d  = '0;
          carry_d = '0;
          mcnt_d  = mcnt_q - MCW'(1);
          if (mac_hi != '0) ovf_d = 1'b1;
        end else begin
          limb_d = limb_q + LCW'(1);
        end
      end
      S_CMP: begin
        if (keep) root_d = trial;
        if (bit_q != '0) bit_d = bit_q - BW'(1);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bit_q   <= '0;
      limb_q  <= '0;
      mcnt_q  <= '0;
      nm1_q   <= '0;
      ovf_q   <= 1'b0;
      root_q  <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      limb_q  <= limb_d;
      mcnt_q  <= mcnt_d;
      nm1_q   <= nm1_d;
      ovf_q   <= ovf_d;
      root_q  <= root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    bound_q <= bound_d;
    acc_q   <= acc_d;
  end

  assign status_o.ready = (state_q == S_IDLE);
  assign status_o.done  = (state_q == S_DONE);
  assign root_o         = root_q;

  a_start_trial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> (state_q == S_TRIAL))
    else $error("A started item did not enter its first trial.");

  a_limb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (limb_q <= LCW'(NL - 1)))
    else $error("The limb index ran past the accumulator.");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (mcnt_q != '0 && nm1_q != '0))
    else $error("A multiplication ran with no multiplications left.");

  a_done_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (bit_q == '0))
    else $error("The result was presented before the last bit was decided.");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !ack_i) |=> (state_q == S_DONE && $stable(root_q)))
    else $error("A finished root changed before it was taken.");

endmodule
`default_nettype wire

// File: src/digit_by_digit_nth_root.sv
// Top level of the digit-by-digit n-th root block with its item handshakes.
//
// An item carries an unsigned Q16.16 radicand and a root power. A power of
// zero is treated as one, and a power above MAX_POWER is taken as MAX_POWER.
// The result item is the greatest root whose power does not exceed the
// radicand, truncated to the same fixed-point format.
// Each root bit is decided by raising the trial root to the power on one
// shared limb multiplier, one accumulator limb per cycle, and then comparing
// exactly against the shifted radicand. A bit takes a trial step, n-1 passes
// over the NL accumulator limbs (NL is 5 at the defaults) and a compare step,
// with fewer passes when the power overflows early. An item decides all
// WORD_BITS bits, most significant first.
// The input side is ready only while the sequencer is idle, so one item is in
// work at a time. A finished root moves into the output register; when the
// receiver stalls, the sequencer holds it and takes no new item until the
// output register frees up. Reset empties the output register and returns
// the sequencer to idle.
`default_nettype none
module digit_by_digit_nth_root #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned MAX_POWER = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [dbdnr_pkg::IN_W-1:0]      radicand_i,
  input  wire logic [dbdnr_pkg::POW_W-1:0]     root_power_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [dbdnr_pkg::IN_W-1:0]      root_value_o
);

  import dbdnr_pkg::*;

  dbdnr_status_t        status;
  logic [WORD_BITS-1:0] core_root;
  logic                 start;
  logic                 take;
  logic                 out_valid_q, out_valid_d;
  logic [IN_W-1:0]      out_root_q, out_root_d;

  assign in_ready_o = status.ready;
  assign start      = in_valid_i && status.ready;
  assign take       = status.done && (!out_valid_q || out_ready_i);

  dbdnr_core #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS),
    .MAX_POWER (MAX_POWER)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .radicand_i   (WORD_BITS'(radicand_i)),
    .root_power_i (root_power_i),
    .ack_i        (take),
    .status_o     (status),
    .root_o       (core_root)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_root_d  = out_root_q;
    if (take) begin
      out_valid_d = 1'b1;
      out_root_d  = IN_W'(core_root);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_root_q <= out_root_d;
  end

  assign out_valid_o  = out_valid_q;
  assign root_value_o = out_root_q;

endmodule
`default_nettype wire

// File: sim/root_checker.sv
// Checker that predicts each n-th root and compares it with the result items.
`default_nettype none
module root_checker #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned MAX_POWER = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_ready_i,
  input  wire logic [dbdnr_pkg::IN_W-1:0]  radicand_i,
  input  wire logic [dbdnr_pkg::POW_W-1:0] root_power_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_ready_i,
  input  wire logic [dbdnr_pkg::IN_W-1:0]  root_value_i,
  output int unsigned                      errors_o,
  output int unsigned                      pending_o
);

  localparam int unsigned WIDE_W = 320;

  logic [dbdnr_pkg::IN_W-1:0] expected_roots[$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic logic [dbdnr_pkg::IN_W-1:0] nth_root_floor(
    input logic [dbdnr_pkg::IN_W-1:0]  radicand,
    input logic [dbdnr_pkg::POW_W-1:0] power
  );
    logic [WIDE_W-1:0]          bound;
    logic [WIDE_W-1:0]          trial_pow;
    logic [dbdnr_pkg::IN_W-1:0] root;
    logic [dbdnr_pkg::IN_W-1:0] trial;
    int                         n;
    int                         b;
    int                         k;
    n = (power == 0) ? 1 : (power > MAX_POWER) ? MAX_POWER : int'(power);
    bound = WIDE_W'(radicand) << (FRAC_BITS * (n - 1));
    root = '0;
    for (b = dbdnr_pkg::IN_W - 1; b >= 0; b--) begin
      trial = root | (dbdnr_pkg::IN_W'(1) << b);
      trial_pow = WIDE_W'(trial);
      for (k = 1; k < n; k++) begin
        trial_pow = trial_pow * WIDE_W'(trial);
      end
      if (trial_pow <= bound) begin
        root = trial;
      end
    end
    return root;
  endfunction

  always @(posedge clk_i) begin
    logic [dbdnr_pkg::IN_W-1:0] want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_roots.push_back(nth_root_floor(radicand_i, root_power_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_roots.size() == 0) begin
          if (errors_o < 10) begin
            $display("Unexpected result item: root_value=%h", root_value_i);
          end
          errors_o <= errors_o + 1;
        end else begin
          want = expected_roots.pop_front();
          if (want !== root_value_i) begin
            if (errors_o < 10) begin
              $display("Mismatch in root_value: expected %h, got %h", want, root_value_i);
            end
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= expected_roots.size();
    end
  end

endmodule
`default_nettype wire

// File: sim/tb.sv
// Testbench top that drives the n-th root block and reports the verdict.
`default_nettype none
module tb;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned MAX_POWER = 8;
  localparam int unsigned NUM_RANDOM = 800;
  localparam int unsigned CYCLE_LIMIT = 6000000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [dbdnr_pkg::IN_W-1:0]  radicand_i;
  logic [dbdnr_pkg::POW_W-1:0] root_power_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [dbdnr_pkg::IN_W-1:0]  root_value_o;
  int unsigned                 errors;
  int unsigned                 pending;
  int unsigned                 cycles;
  int unsigned                 stall_left;
  bit                          idle_on;

  digit_by_digit_nth_root #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS),
    .MAX_POWER(MAX_POWER)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .radicand_i  (radicand_i),
    .root_power_i(root_power_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .root_value_o(root_value_o)
  );

  root_checker #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_POWER(MAX_POWER)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .radicand_i  (radicand_i),
    .root_power_i(root_power_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .root_value_i(root_value_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned pick;
    if (!idle_on) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return 0;
    end else if (pick < 85) begin
      return $urandom_range(1, 3);
    end else if (pick < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        stall_left <= idle_gap();
      end
    end
  end

  function automatic logic [dbdnr_pkg::IN_W-1:0] near_power_radicand(
    input logic [dbdnr_pkg::POW_W-1:0] power
  );
    logic [319:0]               pw;
    logic [dbdnr_pkg::IN_W-1:0] r;
    int                         n;
    int                         k;
    n = (power == 0) ? 1 : (power > MAX_POWER) ? MAX_POWER : int'(power);
    r = $urandom >> $urandom_range(0, 31);
    do begin
      pw = 320'(r);
      for (k = 1; k < n; k++) begin
        pw = pw * 320'(r);
      end
      pw = pw >> (FRAC_BITS * (n - 1));
      if (pw > 320'hFFFF_FFFF) begin
        r = r >> 1;
      end
    end while (pw > 320'hFFFF_FFFF);
    case ($urandom_range(0, 2))
      0: begin
        return (pw == 0) ? '0 : 32'(pw - 1);
      end
      1: begin
        return 32'(pw);
      end
      default: begin
        return (pw == 320'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(pw + 1);
      end
    endcase
  endfunction

  function automatic logic [dbdnr_pkg::IN_W-1:0] random_radicand(
    input logic [dbdnr_pkg::POW_W-1:0] power
  );
    case ($urandom_range(0, 2))
      0: begin
        return $urandom;
      end
      1: begin
        return $urandom >> $urandom_range(0, 31);
      end
      default: begin
        return near_power_radicand(power);
      end
    endcase
  endfunction

  function automatic logic [dbdnr_pkg::POW_W-1:0] random_power();
    if ($urandom_range(0, 4) == 0) begin
      return 4'($urandom_range(0, 15));
    end
    return 4'($urandom_range(1, MAX_POWER));
  endfunction

  task automatic send_root_item(
    input logic [dbdnr_pkg::IN_W-1:0]  radicand,
    input logic [dbdnr_pkg::POW_W-1:0] power
  );
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    radicand_i   <= radicand;
    root_power_i <= power;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    logic [dbdnr_pkg::POW_W-1:0] power;
    int unsigned                 i;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    radicand_i   = '0;
    root_power_i = '0;
    out_ready_i  = 1'b0;
    cycles       = 0;
    stall_left   = 0;
    idle_on      = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_root_item(32'h0000_0000, 4'd1);
    send_root_item(32'h0000_0000, 4'd8);
    send_root_item(32'hFFFF_FFFF, 4'd0);
    send_root_item(32'hFFFF_FFFF, 4'd1);
    send_root_item(32'hFFFF_FFFF, 4'd2);
    send_root_item(32'hFFFF_FFFF, 4'd8);
    send_root_item(32'hFFFF_FFFF, 4'd15);
    send_root_item(32'h0000_0001, 4'd2);
    send_root_item(32'h0000_0001, 4'd8);
    send_root_item(32'h0001_0000, 4'd3);
    send_root_item(32'h0001_0000, 4'd8);
    send_root_item(32'h0004_0000, 4'd2);
    send_root_item(32'h0008_0000, 4'd3);
    send_root_item(32'h0000_FFFF, 4'd2);
    send_root_item(32'h1234_5678, 4'd9);
    send_root_item(32'hA5A5_A5A5, 4'd4);
    send_root_item(32'h5A5A_5A5A, 4'd5);
    send_root_item(32'h0000_0002, 4'd6);
    send_root_item(32'h7FFF_FFFF, 4'd7);
    send_root_item(32'h8000_0000, 4'd10);
    send_root_item(32'hDEAD_BEEF, 4'd11);
    send_root_item(32'h0000_0000, 4'd12);
    send_root_item(32'h0102_0304, 4'd13);
    send_root_item(32'hFFFF_0000, 4'd14);
    send_root_item(32'h3C3C_C3C3, 4'd0);

    for (i = 0; i < NUM_RANDOM; i++) begin
      if (i % 40 == 0) begin
        idle_on <= ($urandom_range(0, 3) != 0);
      end
      power = random_power();
      send_root_item(random_radicand(power), power);
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
